// ----- design/bpc_pkg.sv -----
`default_nettype none
package bpc_pkg;
    localparam int unsigned W = 32;

    // Register indexes on the configuration channel
    localparam logic [2:0] REG_AC_FIRST  = 3'd0;
    localparam logic [2:0] REG_AC_SECOND = 3'd1;
    localparam logic [2:0] REG_B_PAIR    = 3'd2;
    localparam logic [2:0] REG_M_PAIR    = 3'd3;
    localparam logic [2:0] REG_OSS       = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NO_TMP = 2'd1;
    localparam logic [1:0] ST_ZDIV   = 2'd2;

    // Divider request and response
    typedef struct packed {
        logic          start;
        logic          sgn;
        logic [W-1:0]  num;
        logic [W-1:0]  den;
    } t_div_req;

    typedef struct packed {
        logic          busy;
        logic          done;
        logic [W-1:0]  quo;
    } t_div_rsp;

    // Arithmetic shift right of a 32-bit word
    function automatic logic [W-1:0] sar(input logic [W-1:0] x, input logic [4:0] n);
        sar = W'($signed(x) >>> n);
    endfunction

    function automatic logic [W-1:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction
endpackage
`default_nettype wire

// ----- design/bpc_div.sv -----
`default_nettype none
// Restoring divider, one quotient bit per cycle, truncation toward zero.
module bpc_div (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  bpc_pkg::t_div_req i_req,
    output bpc_pkg::t_div_rsp o_rsp
);
    logic [31:0] r_rem, n_rem, r_quo, n_quo, r_den, n_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done, r_neg, n_neg;
    logic [32:0] w_try;
    logic [31:0] w_sh;
    logic [31:0] w_an, w_ad;

    always_comb begin
        w_an = (i_req.sgn && i_req.num[31]) ? 32'(-i_req.num) : i_req.num;
        w_ad = (i_req.sgn && i_req.den[31]) ? 32'(-i_req.den) : i_req.den;
        w_sh = {r_rem[30:0], r_quo[31]};
        w_try = {1'b0, w_sh} - {1'b0, r_den};
        n_rem = r_rem; n_quo = r_quo; n_den = r_den; n_cnt = r_cnt;
        n_busy = r_busy; n_done = 1'b0; n_neg = r_neg;
        if (i_req.start) begin
            // load magnitudes
            n_rem = '0; n_quo = w_an; n_den = w_ad; n_cnt = 6'd32;
            n_busy = 1'b1;
            n_neg = i_req.sgn && (i_req.num[31] ^ i_req.den[31]);
        end else if (r_busy) begin
            // one quotient bit
            if (!w_try[32]) begin
                n_rem = w_try[31:0];
                n_quo = {r_quo[30:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_quo = {r_quo[30:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_rem <= n_rem; r_quo <= n_quo; r_den <= n_den; r_neg <= n_neg;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_neg ? 32'(-r_quo) : r_quo;
endmodule
`default_nettype wire

// ----- design/bpc_mul.sv -----
`default_nettype none
// Shared 32x32 multiplier, low word kept, result registered.
module bpc_mul (
    input  wire         i_clk,
    input  wire  [31:0] i_a,
    input  wire  [31:0] i_b,
    output logic [31:0] o_p
);
    logic [31:0] r_p;
    logic [63:0] w_full;
    assign w_full = {32'd0, i_a} * {32'd0, i_b};
    always_ff @(posedge i_clk) begin
        r_p <= w_full[31:0];
    end
    assign o_p = r_p;
endmodule
`default_nettype wire

// ----- design/barometric_pressure_compensation.sv -----
`default_nettype none
// Barometric sensor compensation.
// s_axis carries one raw reading per request: tdata[23:0] raw_reading,
// tuser[0] mode (0 temperature, 1 pressure). m_axis returns one result per
// request: tdata[15:0] temperature_tenths, tdata[33:16] pressure_pa,
// tdata[35:34] status, tuser[0] kind. Calibration is written on the cfg
// channel (index 0..4, data up to 48 bits) while the block is idle.
// One shared multiplier and one bit-serial divider run under a sequencer.
// A temperature result takes one multiply (S_MUL, then S_WAIT), the launch
// of the division in S_DIV and the 32-step division in S_DWT until its done
// flag. A pressure result takes seven multiplies, the launch and the division,
// three more multiplies (ten in all) and a saturation step in S_FIN.
// Pressure before any temperature answers in the next cycle.
// s_axis_tready is low from acceptance until the result is taken and comes
// back in the cycle after, so one request is in flight at a time.
// A stalled receiver holds the result in the output register; nothing is lost.
// Reset clears calibration, the stored temperature term and its valid flag.
module barometric_pressure_compensation (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [23:0] s_axis_tdata,   // raw_reading[23:0]
    input  wire  [0:0]  s_axis_tuser,   // mode[0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,   // temperature_tenths[15:0], pressure_pa[33:16], status[35:34]
    output logic [0:0]  m_axis_tuser,   // kind[0]
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [47:0] i_cfg_data
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001, S_MUL = 7'b0000010, S_WAIT = 7'b0000100,
        S_DIV  = 7'b0001000, S_DWT = 7'b0010000, S_FIN = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_st;
    logic [47:0] r_ac1, r_ac2;
    logic [31:0] r_bp, r_mp, r_tt;
    logic [1:0]  r_oss;
    logic        r_have;
    logic        r_mode;
    logic [23:0] r_raw;
    logic [3:0]  r_step;
    logic [31:0] r_b6, r_sq, r_x1, r_x2, r_b3, r_b4, r_p;
    logic [31:0] w_a, w_b, w_p;
    logic        r_ov;
    logic [15:0] r_tmp;
    logic [17:0] r_prs;
    logic [1:0]  r_status;
    bpc_pkg::t_div_req w_dreq;
    bpc_pkg::t_div_rsp w_drsp;

    bpc_mul u_mul (.i_clk(i_clk), .i_a(w_a), .i_b(w_b), .o_p(w_p));
    bpc_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, up, w_b7;
    always_comb begin
        ac1 = bpc_pkg::sx16(r_ac1[15:0]);
        ac2 = bpc_pkg::sx16(r_ac1[31:16]);
        ac3 = bpc_pkg::sx16(r_ac1[47:32]);
        ac4 = {16'd0, r_ac2[15:0]};
        ac5 = {16'd0, r_ac2[31:16]};
        ac6 = {16'd0, r_ac2[47:32]};
        b1  = bpc_pkg::sx16(r_bp[15:0]);
        b2  = bpc_pkg::sx16(r_bp[31:16]);
        mc  = bpc_pkg::sx16(r_mp[15:0]);
        md  = bpc_pkg::sx16(r_mp[31:16]);
        up  = {8'd0, r_raw} >> (5'd8 - {3'd0, r_oss});
        w_b7 = r_x1;
    end

    // Select multiplier operands for the current step
    always_comb begin
        w_a = '0; w_b = '0;
        if (!r_mode) begin
            w_a = {16'd0, r_raw[15:0]} - ac6; w_b = ac5;
        end else begin
            case (r_step)
                4'd0:  begin w_a = r_b6; w_b = r_b6; end
                4'd1:  begin w_a = b2;   w_b = r_sq; end
                4'd2:  begin w_a = ac2;  w_b = r_b6; end
                4'd3:  begin w_a = ac3;  w_b = r_b6; end
                4'd4:  begin w_a = b1;   w_b = r_sq; end
                4'd5:  begin w_a = ac4;  w_b = r_x1; end
                4'd6:  begin w_a = up - r_b3; w_b = 32'd50000 >> r_oss; end
                4'd7:  begin w_a = bpc_pkg::sar(r_p, 5'd8); w_b = bpc_pkg::sar(r_p, 5'd8); end
                4'd8:  begin w_a = r_x1; w_b = 32'd3038; end
                4'd9:  begin w_a = 32'(-32'sd7357); w_b = r_p; end
                default: begin w_a = '0; w_b = '0; end
            endcase
        end
    end

    // Divider request
    always_comb begin
        w_dreq = '0;
        if (r_st == S_DIV) begin
            w_dreq.start = 1'b1;
            if (!r_mode) begin
                w_dreq.sgn = 1'b1;
                w_dreq.num = 32'(mc << 11);
                w_dreq.den = r_x1 + md;
            end else begin
                w_dreq.sgn = 1'b0;
                w_dreq.num = w_b7[31] ? w_b7 : {w_b7[30:0], 1'b0};
                w_dreq.den = r_b4;
            end
        end
    end

    assign s_axis_tready = (r_st == S_IDLE);
    assign o_cfg_ready   = (r_st == S_IDLE);
    assign m_axis_tvalid = (r_st == S_OUT);
    assign m_axis_tdata  = {4'd0, r_status, r_prs, r_tmp};
    assign m_axis_tuser  = r_mode;

    logic [31:0] w_tsum, w_tt_new, w_pf, w_sat_t;
    always_comb begin
        w_tt_new = r_x1 + w_drsp.quo;
        w_tsum = bpc_pkg::sar(w_tt_new + 32'd8, 5'd4);
        w_pf = r_p + bpc_pkg::sar(r_x1 + r_x2 + 32'd3791, 5'd4);
        w_sat_t = w_tsum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_step <= '0;
            r_ac1 <= '0; r_ac2 <= '0; r_bp <= '0; r_mp <= '0; r_oss <= '0;
            r_tt <= '0; r_have <= 1'b0; r_mode <= 1'b0;
        end else begin
            case (r_st)
                S_IDLE: begin
                    // take config writes and requests
                    if (i_cfg_valid) begin
                        case (i_cfg_index)
                            bpc_pkg::REG_AC_FIRST:  r_ac1 <= i_cfg_data;
                            bpc_pkg::REG_AC_SECOND: r_ac2 <= i_cfg_data;
                            bpc_pkg::REG_B_PAIR:    r_bp  <= i_cfg_data[31:0];
                            bpc_pkg::REG_M_PAIR:    r_mp  <= i_cfg_data[31:0];
                            bpc_pkg::REG_OSS:       r_oss <= i_cfg_data[1:0];
                            default: ;
                        endcase
                    end
                    if (s_axis_tvalid) begin
                        r_mode <= s_axis_tuser[0];
                        r_raw <= s_axis_tdata;
                        r_step <= '0;
                        r_tmp <= '0; r_prs <= '0;
                        r_b6 <= r_tt - 32'd4000;
                        if (s_axis_tuser[0] && !r_have) begin
                            r_status <= bpc_pkg::ST_NO_TMP;
                            r_st <= S_OUT;
                        end else begin
                            r_status <= bpc_pkg::ST_OK;
                            r_st <= S_MUL;
                        end
                    end
                end
                S_MUL: r_st <= S_WAIT;
                S_WAIT: begin
                    // consume the product of this step
                    if (!r_mode) begin
                        r_x1 <= bpc_pkg::sar(w_p, 5'd15);
                        r_st <= S_DIV;
                    end else begin
                        r_step <= r_step + 4'd1;
                        case (r_step)
                            4'd0: begin
                                r_sq <= bpc_pkg::sar(w_p, 5'd12);
                                r_st <= S_MUL;
                            end
                            4'd1: begin
                                r_x1 <= bpc_pkg::sar(w_p, 5'd11);
                                r_st <= S_MUL;
                            end
                            4'd2: begin
                                r_b3 <= bpc_pkg::sar(
                                    32'(((32'(ac1 << 2) + r_x1 + bpc_pkg::sar(w_p, 5'd11))
                                    << r_oss)) + 32'd2, 5'd2);
                                r_st <= S_MUL;
                            end
                            4'd3: begin
                                r_x1 <= bpc_pkg::sar(w_p, 5'd13);
                                r_st <= S_MUL;
                            end
                            4'd4: begin
                                r_x1 <= bpc_pkg::sar(r_x1 + bpc_pkg::sar(w_p, 5'd16)
                                    + 32'd2, 5'd2) + 32'd32768;
                                r_st <= S_MUL;
                            end
                            4'd5: begin
                                r_b4 <= w_p >> 15;
                                if ((w_p >> 15) == 32'd0) begin
                                    r_status <= bpc_pkg::ST_ZDIV;
                                    r_st <= S_OUT;
                                end else begin
                                    r_st <= S_MUL;
                                end
                            end
                            4'd6: begin r_x1 <= w_p; r_st <= S_DIV; end
                            4'd7: begin r_x1 <= w_p; r_st <= S_MUL; end
                            4'd8: begin
                                r_x1 <= bpc_pkg::sar(w_p, 5'd16);
                                r_st <= S_MUL;
                            end
                            default: begin r_x2 <= bpc_pkg::sar(w_p, 5'd16); r_st <= S_FIN; end
                        endcase
                    end
                end
                S_DIV: begin
                    if (!r_mode && (r_x1 + md) == 32'd0) begin
                        r_status <= bpc_pkg::ST_ZDIV;
                        r_st <= S_OUT;
                    end else begin
                        r_ov <= w_b7[31];
                        r_st <= S_DWT;
                    end
                end
                S_DWT: begin
                    if (w_drsp.done) begin
                        if (!r_mode) begin
                            r_tt <= w_tt_new; r_have <= 1'b1;
                            if ($signed(w_sat_t) > 32'sd32767) r_tmp <= 16'h7FFF;
                            else if ($signed(w_sat_t) < -32'sd32768) r_tmp <= 16'h8000;
                            else r_tmp <= w_sat_t[15:0];
                            r_st <= S_OUT;
                        end else begin
                            r_p <= r_ov ? {w_drsp.quo[30:0], 1'b0} : w_drsp.quo;
                            r_step <= 4'd7;
                            r_st <= S_MUL;
                        end
                    end
                end
                S_FIN: begin
                    if (w_pf[31]) r_prs <= '0;
                    else if (w_pf > 32'd262143) r_prs <= 18'h3FFFF;
                    else r_prs <= w_pf[17:0];
                    r_st <= S_OUT;
                end
                S_OUT: if (m_axis_tready) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- design/bpc_checker.sv -----
`default_nettype none
module bpc_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [39:0] m_axis_tdata,
    input wire [0:0]  m_axis_tuser,
    input wire        o_cfg_ready
);
    // no new request while a result is pending
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("ready during result");
    // a result waiting is held
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
    // temperature results carry no pressure
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[33:16] == 18'd0)
        else $error("pressure in temperature result");
    // accepting a request drops ready next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !o_cfg_ready)
        else $error("ready after accept");
endmodule

bind barometric_pressure_compensation bpc_checker u_bpc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .o_cfg_ready(o_cfg_ready)
);
`default_nettype wire
